// File: design/tmd_pkg.sv
package tmd_pkg;

    localparam int SLOWER_STEPS = 4;
    localparam int RATE_STEPS   = 9;
    localparam int QUEUE_DEPTH  = 32;

    localparam int TIME_W   = 32;
    localparam int LEN_W    = 24;
    localparam int IDX_W    = 4;
    localparam int DUE_W    = 6;
    localparam int FLEN_W   = 24;

    localparam logic [LEN_W-1:0] RESET_BEAT_LENGTH = LEN_W'(500000);
    localparam logic [DUE_W-1:0] DUE_MAX           = '1;

    // Largest exponent above and below the middle index.
    localparam int UP_MAX = RATE_STEPS - 1 - SLOWER_STEPS;
    localparam int E_MAX  = (SLOWER_STEPS > UP_MAX) ? SLOWER_STEPS : UP_MAX;
    localparam int E_W    = $clog2(E_MAX + 1);
    localparam int PUSH_W = (UP_MAX > 0) ? UP_MAX : 1;

    localparam int QA_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    localparam int FIFO_DEPTH = 2;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int FC_W       = $clog2(FIFO_DEPTH + 1);

    // One classified item, handed from the front to the back.
    typedef struct packed {
        logic              is_tick;
        logic [TIME_W-1:0] now;
        logic [LEN_W-1:0]  beat_len;
        logic              flash;
        logic [PUSH_W-1:0] push_cnt;
    } t_entry;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_PUSH,
        BS_READ,
        BS_CHECK,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        logic take;
        logic ram_we;
        logic pop;
        logic load_out;
    } t_bctl;

endpackage

// File: design/tmd_if.sv
interface tmd_in_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [tmd_pkg::TIME_W-1:0] now;
    logic [tmd_pkg::LEN_W-1:0]  period;
    logic [tmd_pkg::IDX_W-1:0]  rate_index;

    modport source (output valid, cmd, now, period, rate_index, input ready);
    modport sink   (input valid, cmd, now, period, rate_index, output ready);
    modport monitor(input valid, ready, cmd, now, period, rate_index);
endinterface

interface tmd_out_if;
    logic                       valid;
    logic                       ready;
    logic                       flash;
    logic [tmd_pkg::FLEN_W-1:0] flash_length;
    logic [tmd_pkg::DUE_W-1:0]  due_count;
    logic                       dropped;

    modport source (output valid, flash, flash_length, due_count, dropped, input ready);
    modport sink   (input valid, flash, flash_length, due_count, dropped, output ready);
    modport monitor(input valid, ready, flash, flash_length, due_count, dropped);
endinterface

// File: design/tempo_multiplier_divider.sv
// Steps: a beat at or below the middle rate is taken and its result loaded directly;
//   a faster beat first writes (factor - 1) flash times, one per cycle, each dropped while
//   the queue is full; a tick examines entries in turn (registered RAM read, then due test).
// The back end takes the next item only after the result transfer, while the front keeps
//   taking items into a two-entry queue.
// Reset: synchronous, active low; clears averages, counters and queue pointers, no sweep.
module tempo_multiplier_divider (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tmd_in_if.sink    i_in,
    tmd_out_if.source o_out
);
    import tmd_pkg::*;

    // Front to back hand-off.
    logic   push;
    logic   pop;
    logic   full;
    logic   q_valid;
    t_entry f_entry;
    t_entry b_entry;

    // Front: take each transfer, update the beat averaging state on a beat, and classify the
    // item into a beat (with its flash decision and push count) or a tick.
    tmd_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_entry(f_entry)
    );

    // Short queue: let the front keep accepting while the back is busy pushing
    // or popping due times.
    tmd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(f_entry),
        .i_pop  (pop),
        .o_full (full),
        .o_valid(q_valid),
        .o_entry(b_entry)
    );

    // Back: own the time queue in RAM, write future flash times for fast beats,
    // drain due times on ticks, and hold each result until the sink takes it.
    tmd_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_entry(b_entry),
        .o_pop  (pop),
        .o_out  (o_out)
    );
endmodule

// File: design/tmd_ram.sv
module tmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/tmd_front.sv
module tmd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tmd_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output tmd_pkg::t_entry o_entry
);
    import tmd_pkg::*;

    logic [LEN_W-1:0]        r_avg, n_avg;
    logic [LEN_W-1:0]        r_beat_len, n_beat_len;
    logic [SLOWER_STEPS-1:0] r_cnt, n_cnt;

    logic [LEN_W:0]              sum;
    logic [IDX_W-1:0]            idx;
    logic [E_W-1:0]              e;
    logic [PUSH_W:0]             up_ones;
    logic [SLOWER_STEPS:0]       dn_ones;
    logic [LEN_W+SLOWER_STEPS-1:0] wide;
    logic                        beat_flash;
    logic [PUSH_W-1:0]           push_cnt;
    logic                        accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign o_push     = accept;

    always_comb begin
        sum        = {1'b0, r_avg} + {1'b0, i_in.period};
        n_avg      = sum[LEN_W:1];
        n_cnt      = r_cnt + 1'b1;
        idx        = (i_in.rate_index >= IDX_W'(RATE_STEPS)) ? IDX_W'(RATE_STEPS - 1)
                                                              : i_in.rate_index;
        e          = '0;
        up_ones    = '0;
        dn_ones    = '0;
        wide       = '0;
        beat_flash = 1'b1;
        push_cnt   = '0;
        n_beat_len = n_avg;
        priority if (idx > IDX_W'(SLOWER_STEPS)) begin
            // Faster: shorten the beat and queue the extra flashes.
            e          = E_W'(idx - IDX_W'(SLOWER_STEPS));
            n_beat_len = n_avg >> e;
            up_ones    = (PUSH_W+1)'(1) << e;
            push_cnt   = PUSH_W'(up_ones - 1'b1);
        end else if (idx == IDX_W'(SLOWER_STEPS)) begin
            n_beat_len = n_avg;
        end else begin
            // Slower: stretch the beat, flash on every 2^e-th beat.
            e          = E_W'(IDX_W'(SLOWER_STEPS) - idx);
            wide       = {{SLOWER_STEPS{1'b0}}, n_avg} << e;
            n_beat_len = (|wide[LEN_W+SLOWER_STEPS-1:LEN_W]) ? '1 : wide[LEN_W-1:0];
            dn_ones    = (SLOWER_STEPS+1)'(1) << e;
            beat_flash = (n_cnt & SLOWER_STEPS'(dn_ones - 1'b1)) == '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg      <= '0;
            r_beat_len <= RESET_BEAT_LENGTH;
            r_cnt      <= '0;
        end else if (accept && !i_in.cmd) begin
            r_avg      <= n_avg;
            r_beat_len <= n_beat_len;
            r_cnt      <= n_cnt;
        end
    end

    always_comb begin
        o_entry.is_tick = i_in.cmd;
        o_entry.now     = i_in.now;
        if (i_in.cmd) begin
            o_entry.beat_len = r_beat_len;
            o_entry.flash    = 1'b0;
            o_entry.push_cnt = '0;
        end else begin
            o_entry.beat_len = n_beat_len;
            o_entry.flash    = beat_flash;
            o_entry.push_cnt = push_cnt;
        end
    end
endmodule

// File: design/tmd_fifo.sv
module tmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tmd_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output tmd_pkg::t_entry o_entry
);
    import tmd_pkg::*;

    t_entry          r_mem [FIFO_DEPTH];
    logic [FP_W-1:0] r_wp, r_rp;
    logic [FC_W-1:0] r_cnt;

    assign o_full  = r_cnt == FC_W'(FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == FP_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == FP_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// File: design/tmd_back.sv
module tmd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  tmd_pkg::t_entry i_entry,
    output logic            o_pop,
    tmd_out_if.source       o_out
);
    import tmd_pkg::*;

    t_bstate           r_state, n_state;
    t_bctl             ctl;
    t_entry            r_cur;
    logic [TIME_W-1:0] r_acc;
    logic [PUSH_W-1:0] r_left;
    logic              r_drop;
    logic [DUE_W-1:0]  r_due;
    logic [QA_W-1:0]   r_head, r_tail;
    logic [FILL_W-1:0] r_fill;

    logic              r_out_valid;
    logic              r_out_flash;
    logic [FLEN_W-1:0] r_out_flen;
    logic [DUE_W-1:0]  r_out_due;
    logic              r_out_drop;

    logic [TIME_W-1:0] rdata;
    logic [TIME_W-1:0] age;
    logic              is_due;
    logic              q_full;
    logic              fin_flash;
    logic [LEN_W+1:0]  len3;

    tmd_ram #(
        .WIDTH(TIME_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ctl.ram_we),
        .i_waddr(r_tail),
        .i_wdata(r_acc),
        .i_raddr(r_head),
        .o_rdata(rdata)
    );

    assign age    = r_cur.now - rdata;
    assign is_due = !age[TIME_W-1];
    assign q_full = r_fill == FILL_W'(QUEUE_DEPTH);
    assign o_pop  = ctl.take;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_valid && !r_out_valid) begin
                    priority if (i_entry.is_tick) begin
                        n_state = (r_fill != '0) ? BS_READ : BS_DONE;
                    end else if (i_entry.push_cnt != '0) begin
                        n_state = BS_PUSH;
                    end else begin
                        n_state = BS_DONE;
                    end
                end
            end
            BS_PUSH:  n_state = (r_left == PUSH_W'(1)) ? BS_DONE : BS_PUSH;
            BS_READ:  n_state = BS_CHECK;
            BS_CHECK: n_state = (is_due && r_fill > FILL_W'(1)) ? BS_READ : BS_DONE;
            BS_DONE:  n_state = BS_IDLE;
            default:  n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (r_state)
            BS_IDLE:  ctl.take     = i_valid && !r_out_valid;
            BS_PUSH:  ctl.ram_we   = !q_full;
            BS_CHECK: ctl.pop      = is_due;
            BS_DONE:  ctl.load_out = 1'b1;
            default:  ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            if (ctl.ram_we) begin
                r_tail <= (r_tail == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                r_fill <= r_fill + 1'b1;
            end else if (ctl.pop) begin
                r_head <= (r_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // Per-item working registers.
    always_ff @(posedge i_clk) begin
        if (ctl.take) begin
            r_cur  <= i_entry;
            r_acc  <= i_entry.now + TIME_W'(i_entry.beat_len);
            r_left <= i_entry.push_cnt;
            r_drop <= 1'b0;
            r_due  <= '0;
        end
        if (r_state == BS_PUSH) begin
            r_acc  <= r_acc + TIME_W'(r_cur.beat_len);
            r_left <= r_left - 1'b1;
            if (q_full) begin
                r_drop <= 1'b1;
            end
        end
        if (ctl.pop && r_due != DUE_MAX) begin
            r_due <= r_due + 1'b1;
        end
    end

    assign fin_flash = r_cur.is_tick ? (r_due != '0) : r_cur.flash;
    assign len3      = {2'b00, r_cur.beat_len} + {1'b0, r_cur.beat_len, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load_out) begin
            r_out_flash <= fin_flash;
            r_out_flen  <= fin_flash ? FLEN_W'(len3 >> 2) : '0;
            r_out_due   <= r_cur.is_tick ? r_due : '0;
            r_out_drop  <= r_cur.is_tick ? 1'b0 : r_drop;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.flash        = r_out_flash;
    assign o_out.flash_length = r_out_flen;
    assign o_out.due_count    = r_out_due;
    assign o_out.dropped      = r_out_drop;
endmodule

// File: design/tmd_checker.sv
module tmd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    tmd_in_if.sink    i_in,
    tmd_out_if.source o_out
);
    import tmd_pkg::*;

    // Result register is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    // No flash means no flash length.
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.flash) |-> (o_out.flash_length == '0))
        else $error("flash length without flash");

    // Popped times always flash and never report a drop.
    a_due_flash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.due_count != '0) |-> (o_out.flash && !o_out.dropped))
        else $error("popped times without flash or with drop");

    // A waiting input transfer holds valid and its payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && !i_in.ready) |=>
        (i_in.valid && $stable({i_in.cmd, i_in.now, i_in.period, i_in.rate_index})))
        else $error("input changed while waiting");

    // Flash length is three quarters of a 24-bit length at most.
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.flash_length <= FLEN_W'(12582911)))
        else $error("flash length out of range");
endmodule

bind tempo_multiplier_divider tmd_checker u_tmd_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_in   (i_in),
    .o_out  (o_out)
);
